// ===== sv/svh_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted value histogram package
// Shared constants, command and status codes, and the compare flag type.
// ----------------------------------------------------------------------------
package svh_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;
	localparam int DEFAULT_KEY_WIDTH   = 64;
	localparam int DEFAULT_COUNT_WIDTH = 32;

	// Stream payload widths.
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 120;
	localparam int M_TUSER_W = 3;

	// Command codes.
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_HIT    = 3'd0;
	localparam logic [2:0] STAT_INSERT = 3'd1;
	localparam logic [2:0] STAT_FULL   = 3'd2;
	localparam logic [2:0] STAT_READ   = 3'd3;
	localparam logic [2:0] STAT_EMPTY  = 3'd4;
	localparam logic [2:0] STAT_CLEAR  = 3'd5;

	// Outcome of comparing a stored key against the probe key.
	typedef struct packed {
		logic eq;
		logic gt;
	} svh_cmp_t;

endpackage

// ===== sv/svh_table.sv =====
// ----------------------------------------------------------------------------
// Histogram table
// Key and count storage with one write port and one registered read port,
// followed by the shared key comparator and saturating count incrementer.
// ----------------------------------------------------------------------------
module svh_table #(
	parameter int TABLE_DEPTH = svh_pkg::DEFAULT_TABLE_DEPTH,
	parameter int KEY_WIDTH   = svh_pkg::DEFAULT_KEY_WIDTH,
	parameter int COUNT_WIDTH = svh_pkg::DEFAULT_COUNT_WIDTH
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	input  logic                       wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [KEY_WIDTH-1:0]       wr_key,
	input  logic [COUNT_WIDTH-1:0]     wr_count,
	input  logic [KEY_WIDTH-1:0]       probe_key,
	output logic [KEY_WIDTH-1:0]       rd_key,
	output logic [COUNT_WIDTH-1:0]     rd_count,
	output logic [COUNT_WIDTH-1:0]     cnt_inc,
	output svh_pkg::svh_cmp_t          flags
);

	localparam int EW = KEY_WIDTH + COUNT_WIDTH;

	logic [EW-1:0] mem_q [TABLE_DEPTH];
	logic [EW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_key, wr_count};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_key   = rd_data_q[EW-1:COUNT_WIDTH];
	assign rd_count = rd_data_q[COUNT_WIDTH-1:0];

	assign flags.eq = (rd_key == probe_key);
	assign flags.gt = (rd_key > probe_key);

	// The count holds once it reaches its all-ones maximum.
	assign cnt_inc = (rd_count == {COUNT_WIDTH{1'b1}}) ? rd_count
		: rd_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

endmodule

// ===== sv/sorted_value_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted value histogram unit
// Histogram of distinct keys kept in ascending order with occurrence counts.
// ----------------------------------------------------------------------------
// An add walks the table one entry per cycle up to the first key that is equal
// or larger, then either bumps that count or opens a slot by moving the
// following entries up one place, again one per cycle, and writes the new key
// with a count of one; on a full table a new key is dropped with status full.
// The walk and the move are paced by the single read port and single write
// port of the table, and a result still waiting in the output register holds
// back the next one. A new command is taken as soon as the previous result
// sits in the output register, even if that result is not yet taken.
// A read at an index at or beyond entries_used answers with status empty.
// ----------------------------------------------------------------------------
module sorted_value_histogram_unit #(
	parameter int TABLE_DEPTH = svh_pkg::DEFAULT_TABLE_DEPTH,
	parameter int KEY_WIDTH   = svh_pkg::DEFAULT_KEY_WIDTH,
	parameter int COUNT_WIDTH = svh_pkg::DEFAULT_COUNT_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// sample_key[63:0], read_index[71:64]
	input  logic [svh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  logic [svh_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// position[7:0], entry_key[71:8], entry_count[103:72],
	// entries_used[112:104], zero fill[119:113]
	output logic [svh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status[2:0]
	output logic [svh_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam logic [IW-1:0] DEPTH_W = IW'(TABLE_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SEARCH = 7'b0000010,
		ST_HIT    = 7'b0000100,
		ST_SHIFT  = 7'b0001000,
		ST_INSERT = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [IW-1:0]          used_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [AW-1:0]          idx_q;
	logic [IW-1:0]          rem_q;
	logic [AW-1:0]          src_q;
	logic                   pend_q;
	logic [AW-1:0]          pend_addr_q;
	logic [2:0]             res_status_q;
	logic [7:0]             res_pos_q;
	logic [63:0]            res_key_q;
	logic [31:0]            res_count_q;
	logic                   m_tvalid_q;
	logic [svh_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [svh_pkg::M_TUSER_W-1:0] m_tuser_q;

	// Table port controls.
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [KEY_WIDTH-1:0]   wr_key;
	logic [COUNT_WIDTH-1:0] wr_count;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [COUNT_WIDTH-1:0] rd_count;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	svh_pkg::svh_cmp_t      flags;

	// Input fields.
	logic [1:0]             in_cmd;
	logic [KEY_WIDTH-1:0]   in_key;
	logic [7:0]             in_ridx;
	logic [AW+7:0]          ridx_ext;
	logic                   ridx_valid;
	logic                   accept;

	// Width adaption toward the fixed output fields.
	logic [KEY_WIDTH+63:0]   rd_key_wide;
	logic [KEY_WIDTH+63:0]   key_q_wide;
	logic [COUNT_WIDTH+31:0] rd_count_wide;
	logic [COUNT_WIDTH+31:0] cnt_inc_wide;
	logic [AW+7:0]           idx_wide;
	logic [IW+8:0]           used_wide;

	logic [IW-1:0]           idx_inc;
	logic                    last_entry;
	logic                    table_full;

	assign in_cmd  = s_axis_tuser[1:0];
	assign in_key  = s_axis_tdata[KEY_WIDTH-1:0];
	assign in_ridx = s_axis_tdata[71:64];

	assign ridx_ext   = {{AW{1'b0}}, in_ridx};
	assign ridx_valid = ({{IW{1'b0}}, in_ridx} < {8'b0, used_q});

	assign rd_key_wide   = {64'b0, rd_key};
	assign key_q_wide    = {64'b0, key_q};
	assign rd_count_wide = {32'b0, rd_count};
	assign cnt_inc_wide  = {32'b0, cnt_inc};
	assign idx_wide      = {8'b0, idx_q};
	assign used_wide     = {9'b0, used_q};

	assign idx_inc    = IW'(idx_q) + {{(IW-1){1'b0}}, 1'b1};
	assign last_entry = (idx_inc == used_q);
	assign table_full = (used_q == DEPTH_W);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	svh_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_table (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_count  (wr_count),
		.probe_key (key_q),
		.rd_key    (rd_key),
		.rd_count  (rd_count),
		.cnt_inc   (cnt_inc),
		.flags     (flags)
	);

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_key   = key_q;
		wr_count = COUNT_WIDTH'(1);
		case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd == svh_pkg::CMD_ADD && used_q != '0) begin
					rd_en = 1'b1;
				end else if (accept && in_cmd == svh_pkg::CMD_READ && ridx_valid) begin
					rd_en   = 1'b1;
					rd_addr = ridx_ext[AW-1:0];
				end
			end
			ST_SEARCH: begin
				if (!flags.eq && !flags.gt && !last_entry) begin
					rd_en   = 1'b1;
					rd_addr = idx_inc[AW-1:0];
				end
			end
			ST_HIT: begin
				wr_en    = 1'b1;
				wr_key   = rd_key;
				wr_count = cnt_inc;
			end
			ST_SHIFT: begin
				if (pend_q) begin
					wr_en    = 1'b1;
					wr_addr  = pend_addr_q;
					wr_key   = rd_key;
					wr_count = rd_count;
				end
				if (rem_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = src_q;
				end
			end
			ST_INSERT: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			key_q        <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			src_q        <= '0;
			pend_q       <= 1'b0;
			pend_addr_q  <= '0;
			res_status_q <= svh_pkg::STAT_EMPTY;
			res_pos_q    <= '0;
			res_key_q    <= '0;
			res_count_q  <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (m_tvalid_q && m_axis_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q       <= in_key;
						idx_q       <= '0;
						res_pos_q   <= (in_cmd == svh_pkg::CMD_READ) ? in_ridx : '0;
						res_key_q   <= '0;
						res_count_q <= '0;
						case (in_cmd)
							svh_pkg::CMD_ADD: begin
								state_q <= (used_q == '0) ? ST_INSERT : ST_SEARCH;
							end
							svh_pkg::CMD_READ: begin
								if (ridx_valid) begin
									state_q <= ST_READ;
								end else begin
									res_status_q <= svh_pkg::STAT_EMPTY;
									state_q      <= ST_EMIT;
								end
							end
							svh_pkg::CMD_CLEAR: begin
								used_q       <= '0;
								res_status_q <= svh_pkg::STAT_CLEAR;
								state_q      <= ST_EMIT;
							end
							default: begin
								res_status_q <= svh_pkg::STAT_EMPTY;
								state_q      <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (flags.eq) begin
						state_q <= ST_HIT;
					end else if (flags.gt || last_entry) begin
						if (table_full) begin
							res_status_q <= svh_pkg::STAT_FULL;
							res_pos_q    <= '0;
							res_key_q    <= key_q_wide[63:0];
							res_count_q  <= '0;
							state_q      <= ST_EMIT;
						end else if (flags.gt) begin
							// Open a slot at idx_q by moving the tail up one place.
							rem_q   <= used_q - IW'(idx_q);
							src_q   <= AW'(used_q - {{(IW-1){1'b0}}, 1'b1});
							pend_q  <= 1'b0;
							state_q <= ST_SHIFT;
						end else begin
							idx_q   <= idx_inc[AW-1:0];
							state_q <= ST_INSERT;
						end
					end else begin
						idx_q <= idx_inc[AW-1:0];
					end
				end
				ST_HIT: begin
					res_status_q <= svh_pkg::STAT_HIT;
					res_pos_q    <= idx_wide[7:0];
					res_key_q    <= rd_key_wide[63:0];
					res_count_q  <= cnt_inc_wide[31:0];
					state_q      <= ST_EMIT;
				end
				ST_SHIFT: begin
					if (rem_q != '0) begin
						pend_q      <= 1'b1;
						pend_addr_q <= src_q + {{(AW-1){1'b0}}, 1'b1};
						src_q       <= src_q - {{(AW-1){1'b0}}, 1'b1};
						rem_q       <= rem_q - {{(IW-1){1'b0}}, 1'b1};
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_INSERT;
						end
					end
				end
				ST_INSERT: begin
					used_q       <= used_q + {{(IW-1){1'b0}}, 1'b1};
					res_status_q <= svh_pkg::STAT_INSERT;
					res_pos_q    <= idx_wide[7:0];
					res_key_q    <= key_q_wide[63:0];
					res_count_q  <= 32'd1;
					state_q      <= ST_EMIT;
				end
				ST_READ: begin
					res_status_q <= svh_pkg::STAT_READ;
					res_key_q    <= rd_key_wide[63:0];
					res_count_q  <= rd_count_wide[31:0];
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'b0, used_wide[8:0], res_count_q, res_key_q, res_pos_q};
						m_tuser_q  <= res_status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The table never holds more entries than it has rows.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_W)
		else $error("entry count exceeds table depth");

	// The number of entries still to move never exceeds the entries held.
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (rem_q <= used_q))
		else $error("shift length exceeds used entries");

	// Ready is low in the cycle after every accepted command.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("ready held across an accepted command");

	// An insert result always reports a non-empty table.
	a_insert_used: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q == svh_pkg::STAT_INSERT) |-> (m_tdata_q[112:104] != 9'd0))
		else $error("insert reported with an empty table");

	// A clear result always reports an empty table.
	a_clear_used: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q == svh_pkg::STAT_CLEAR) |-> (m_tdata_q[112:104] == 9'd0))
		else $error("clear reported with entries left");

endmodule

// ===== dv/sorted_value_histogram_unit_test.sv =====
// ----------------------------------------------------------------------------
// Sorted value histogram unit testbench
// Sends add, read, clear and unused commands over the input stream and checks
// every result against a cycle-free model of the sorted key table. The run
// covers first, middle and last insert positions, hits and drops on a full
// table, reads past the used entries and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module sorted_value_histogram_unit_test;

	localparam int CLK_PERIOD   = 20;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int DEPTH        = svh_pkg::DEFAULT_TABLE_DEPTH;
	localparam int POOL_SIZE    = 48;
	localparam int FILL_ADDS    = 262;

	// The package names no code for the fourth command; the block treats it as a no-op.
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic [63:0] KEY_ONE      = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] KEY_TWO      = 64'h4000_0000_0000_0000;
	localparam logic [63:0] KEY_HALF     = 64'h3FE0_0000_0000_0000;
	localparam logic [63:0] KEY_MAX_REAL = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] sample_key;
		logic [7:0]  read_index;
	} hist_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  position;
		logic [63:0] entry_key;
		logic [31:0] entry_count;
		logic [8:0]  entries_used;
	} hist_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [svh_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [svh_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [svh_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [svh_pkg::M_TUSER_W-1:0] m_axis_tuser;

	// Model of the table contents.
	logic [63:0] table_keys [0:DEPTH-1];
	logic [31:0] table_counts [0:DEPTH-1];
	logic [8:0]  table_used = '0;

	hist_cmd_t    command_queue [$];
	hist_result_t answer_queue [$];
	hist_result_t answer_head;
	logic [63:0]  key_pool [0:POOL_SIZE-1];

	int  mismatch_count = 0;
	int  commands_sent = 0;
	int  results_seen = 0;
	int  status_tally [0:7];
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  ready_cycles = 0;
	logic offer;

	sorted_value_histogram_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// sample_key[63:0], read_index[71:64]
		.s_axis_tdata  (s_axis_tdata),
		// cmd[1:0]
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// position[7:0], entry_key[71:8], entry_count[103:72], entries_used[112:104]
		.m_axis_tdata  (m_axis_tdata),
		// status[2:0]
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Applies one command to the table model and returns the answer it gives.
	function automatic hist_result_t histogram_apply(hist_cmd_t c);
		hist_result_t res;
		int           i;
		int           slot;
		res = '0;
		case (c.cmd)
			svh_pkg::CMD_ADD: begin
				slot = -1;
				for (i = 0; i < int'(table_used); i++)
					if (slot < 0 && table_keys[i] == c.sample_key)
						slot = i;
				if (slot >= 0) begin
					if (table_counts[slot] != COUNT_MAX)
						table_counts[slot] = table_counts[slot] + 32'd1;
					res.status      = svh_pkg::STAT_HIT;
					res.position    = slot[7:0];
					res.entry_key   = table_keys[slot];
					res.entry_count = table_counts[slot];
				end else if (table_used >= DEPTH) begin
					res.status    = svh_pkg::STAT_FULL;
					res.entry_key = c.sample_key;
				end else begin
					slot = int'(table_used);
					for (i = int'(table_used) - 1; i >= 0; i--)
						if (table_keys[i] > c.sample_key)
							slot = i;
					for (i = int'(table_used); i > slot; i--) begin
						table_keys[i]   = table_keys[i-1];
						table_counts[i] = table_counts[i-1];
					end
					table_keys[slot]   = c.sample_key;
					table_counts[slot] = 32'd1;
					table_used         = table_used + 9'd1;
					res.status      = svh_pkg::STAT_INSERT;
					res.position    = slot[7:0];
					res.entry_key   = c.sample_key;
					res.entry_count = 32'd1;
				end
			end
			svh_pkg::CMD_READ: begin
				res.position = c.read_index;
				if ({1'b0, c.read_index} < table_used) begin
					res.status      = svh_pkg::STAT_READ;
					res.entry_key   = table_keys[c.read_index];
					res.entry_count = table_counts[c.read_index];
				end else begin
					res.status = svh_pkg::STAT_EMPTY;
				end
			end
			svh_pkg::CMD_CLEAR: begin
				table_used = '0;
				res.status = svh_pkg::STAT_CLEAR;
			end
			default: res.status = svh_pkg::STAT_EMPTY;
		endcase
		res.entries_used = table_used;
		return res;
	endfunction

	task automatic queue_command(input logic [1:0] cmd, input logic [63:0] key,
			input logic [7:0] idx);
		hist_cmd_t c;
		c.cmd        = cmd;
		c.sample_key = key;
		c.read_index = idx;
		command_queue.insert(command_queue.size(), c);
	endtask

	// Fills the table past its depth, then hits, drops and reads on the full table.
	task automatic queue_fill_run();
		logic [63:0] kept [0:19];
		logic [63:0] k;
		int          i;
		queue_command(svh_pkg::CMD_CLEAR, rand_key(), 8'($urandom_range(0, 255)));
		for (i = 0; i < FILL_ADDS; i++) begin
			k = rand_key();
			if (i < 20)
				kept[i] = k;
			queue_command(svh_pkg::CMD_ADD, k, 8'($urandom_range(0, 255)));
		end
		queue_command(svh_pkg::CMD_READ, rand_key(), 8'd0);
		queue_command(svh_pkg::CMD_READ, rand_key(), 8'd255);
		for (i = 0; i < 16; i++)
			queue_command(svh_pkg::CMD_READ, rand_key(), 8'($urandom_range(0, 255)));
		for (i = 0; i < 10; i++)
			queue_command(svh_pkg::CMD_ADD, kept[$urandom_range(0, 19)],
				8'($urandom_range(0, 255)));
		for (i = 0; i < 5; i++)
			queue_command(svh_pkg::CMD_ADD, rand_key(), 8'($urandom_range(0, 255)));
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Input side: one command per transfer, with random gaps between transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			gap_left = 0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				answer_queue.insert(answer_queue.size(),
					histogram_apply(command_queue.pop_front()));
				commands_sent++;
				offer = 1'b0;
				gap_left = (commands_sent % 250 < 60) ? 0 : draw_gap();
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_queue.size() > 0) begin
					offer = 1'b1;
					s_axis_tdata <= {command_queue[0].read_index, command_queue[0].sample_key};
					s_axis_tuser <= command_queue[0].cmd;
				end
			end
			s_axis_tvalid <= offer;
		end
	end

	// Result side ready: random stalls, plus two long hold-offs that back up the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			ready_cycles = 0;
		end else begin
			ready_cycles++;
			if (ready_cycles == 2000 || ready_cycles == 120000)
				hold_left = 600;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (ready_cycles % 3000 > 700 && $urandom_range(0, 99) < 30)
					stall_left = draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (answer_queue.size() == 0) begin
				report_mismatch("result with nothing pending", m_axis_tdata[71:8], '0);
			end else begin
				answer_head = answer_queue.pop_front();
				status_tally[answer_head.status]++;
				if (m_axis_tuser[2:0] !== answer_head.status)
					report_mismatch("status", m_axis_tuser[2:0], answer_head.status);
				if (m_axis_tdata[7:0] !== answer_head.position)
					report_mismatch("position", m_axis_tdata[7:0], answer_head.position);
				if (m_axis_tdata[71:8] !== answer_head.entry_key)
					report_mismatch("entry_key", m_axis_tdata[71:8], answer_head.entry_key);
				if (m_axis_tdata[103:72] !== answer_head.entry_count)
					report_mismatch("entry_count", m_axis_tdata[103:72],
						answer_head.entry_count);
				if (m_axis_tdata[112:104] !== answer_head.entries_used)
					report_mismatch("entries_used", m_axis_tdata[112:104],
						answer_head.entries_used);
			end
		end
	end

	initial begin
		int          b;
		int          k;
		int          r;
		logic [63:0] key;
		logic [7:0]  idx;
		for (k = 0; k < 8; k++)
			status_tally[k] = 0;
		for (k = 0; k < POOL_SIZE; k++)
			key_pool[k] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = KEY_ONE;

		// Directed part: empty table, insert at front, middle and end, hits at both ends.
		queue_command(svh_pkg::CMD_READ, rand_key(), 8'd0);
		queue_command(CMD_NOP, '1, 8'hFF);
		queue_command(svh_pkg::CMD_ADD, KEY_ONE, 8'hFF);
		queue_command(svh_pkg::CMD_ADD, KEY_ONE, 8'h00);
		queue_command(svh_pkg::CMD_ADD, 64'd0, 8'h5A);
		queue_command(svh_pkg::CMD_ADD, '1, 8'hA5);
		queue_command(svh_pkg::CMD_ADD, KEY_TWO, 8'd0);
		queue_command(svh_pkg::CMD_ADD, KEY_HALF, 8'd0);
		queue_command(svh_pkg::CMD_ADD, '1, 8'd0);
		queue_command(svh_pkg::CMD_ADD, 64'd0, 8'd0);
		for (k = 0; k < 6; k++)
			queue_command(svh_pkg::CMD_READ, rand_key(), k[7:0]);
		queue_command(svh_pkg::CMD_READ, '1, 8'd255);
		queue_command(CMD_NOP, 64'd0, 8'd0);
		queue_command(svh_pkg::CMD_CLEAR, rand_key(), 8'hFF);
		queue_command(svh_pkg::CMD_READ, 64'd0, 8'd0);
		queue_command(svh_pkg::CMD_ADD, KEY_MAX_REAL, 8'd0);
		queue_command(svh_pkg::CMD_ADD, 64'd1, 8'd0);
		queue_command(svh_pkg::CMD_READ, rand_key(), 8'd1);
		queue_command(svh_pkg::CMD_CLEAR, 64'd0, 8'd0);

		// Random part: mixed bursts, with two full-table runs among them.
		// A saturated count cannot be reached at a 32-bit count width in this run.
		for (b = 0; b < 14; b++) begin
			if (b == 0 || b == 7)
				queue_fill_run();
			for (k = 0; k < 40; k++) begin
				r = $urandom_range(0, 99);
				idx = 8'($urandom_range(0, 255));
				if (r < 60) begin
					key = ($urandom_range(0, 99) < 65) ? key_pool[$urandom_range(0, POOL_SIZE-1)]
						: rand_key();
					queue_command(svh_pkg::CMD_ADD, key, idx);
				end else if (r < 90) begin
					if ($urandom_range(0, 3) != 0)
						idx = 8'($urandom_range(0, 40));
					queue_command(svh_pkg::CMD_READ, rand_key(), idx);
				end else if (r < 94) begin
					queue_command(svh_pkg::CMD_CLEAR, rand_key(), idx);
				end else begin
					queue_command(CMD_NOP, rand_key(), idx);
				end
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (command_queue.size() != 0 || answer_queue.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("covered %0d commands: %0d hits, %0d inserts, %0d drops on a full table",
			commands_sent, status_tally[svh_pkg::STAT_HIT], status_tally[svh_pkg::STAT_INSERT],
			status_tally[svh_pkg::STAT_FULL]);
		$display("%0d reads, %0d empty or unused answers, %0d clears, %0d results checked",
			status_tally[svh_pkg::STAT_READ], status_tally[svh_pkg::STAT_EMPTY],
			status_tally[svh_pkg::STAT_CLEAR], results_seen);
		if (mismatch_count == 0)
			$display("sorted_value_histogram_unit_test passed");
		else
			$display("sorted_value_histogram_unit_test failed");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d commands and %0d results outstanding",
			command_queue.size(), answer_queue.size());
		$display("sorted_value_histogram_unit_test failed");
		$finish;
	end

endmodule
